/* design/assert_macros.svh */
// assert_macros.svh: concurrent assertion macros for the checker files.
// No dependencies; included by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_CLKD_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/wcsv_pkg.sv */
// wcsv_pkg: sizes, types, register codes and helper functions of the
// windowed class score vote block. No dependencies.
package wcsv_pkg;

   // Storage sizes.
   localparam int WINDOW_DEPTH = 64;
   localparam int MAX_CLASSES  = 16;
   localparam int SCORE_WIDTH  = 16;
   localparam int QUEUE_DEPTH  = 2;

   // Derived widths.
   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int CLS_W  = $clog2(MAX_CLASSES);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int POS_W  = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W  = SCORE_WIDTH + SLOT_W;
   localparam int ADDR_W = SLOT_W + CLS_W;

   // Configuration registers.
   localparam int WLEN_W     = 7;
   localparam int CCNT_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT   = 1'd1;
   localparam logic [WLEN_W-1:0]    WLEN_RESET        = 7'd50;
   localparam logic [CCNT_W-1:0]    CCNT_RESET        = 5'd16;

   typedef logic signed [SCORE_WIDTH-1:0] score_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAX_CLASSES-1:0][SCORE_WIDTH-1:0] frame_type;

   typedef enum logic [0:0] {
      TOKEN_FRAME = 1'b0,
      TOKEN_CLEAR = 1'b1
   } token_kind_type;

   // One entry of the queue between front and back.
   typedef struct packed {
      token_kind_type     kind;
      frame_type          scores;
      logic [CLS_W-1:0]   winner;
   } token_type;

   // Effective configuration seen by front and back.
   typedef struct packed {
      logic [FILL_W-1:0] length;
      logic [POS_W-1:0]  classes;
   } cfg_type;

   // Window length limited to 1 .. WINDOW_DEPTH.
   function automatic logic [FILL_W-1:0] eff_length(input logic [WLEN_W-1:0] wl);
      logic [FILL_W-1:0] len;
      if (wl == '0) begin
         len = FILL_W'(1);
      end else if (int'(wl) > WINDOW_DEPTH) begin
         len = FILL_W'(WINDOW_DEPTH);
      end else begin
         len = FILL_W'(wl);
      end
      return len;
   endfunction

   // Class count limited to 1 .. MAX_CLASSES.
   function automatic logic [POS_W-1:0] eff_classes(input logic [CCNT_W-1:0] cc);
      logic [POS_W-1:0] n;
      if (cc == '0) begin
         n = POS_W'(1);
      end else if (int'(cc) > MAX_CLASSES) begin
         n = POS_W'(MAX_CLASSES);
      end else begin
         n = POS_W'(cc);
      end
      return n;
   endfunction

endpackage

/* design/wcsv_req_if.sv */
// wcsv_req_if: score input channel (valid, ready and one score element).
// Depends on wcsv_pkg.
interface wcsv_req_if import wcsv_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   score_type score;
   logic      frame_end;

   modport source(output valid, output mode, output score, output frame_end, input ready);
   modport sink(input valid, input mode, input score, input frame_end, output ready);
endinterface

/* design/wcsv_rsp_if.sv */
// wcsv_rsp_if: decision result channel (valid, ready and one decision).
// Depends on wcsv_pkg.
interface wcsv_rsp_if import wcsv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CLS_W-1:0]  decided_class;
   logic              unknown;
   logic [FILL_W-1:0] top_votes;
   logic [FILL_W-1:0] frames_held;

   modport source(output valid, output decided_class, output unknown, output top_votes,
                  output frames_held, input ready);
   modport sink(input valid, input decided_class, input unknown, input top_votes,
                input frames_held, output ready);
endinterface

/* design/wcsv_ram.sv */
// wcsv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcsv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/wcsv_front.sv */
// wcsv_front: collects the scores of one frame, finds its argmax class and
// hands the frame, or a clear, to the queue. Depends on wcsv_pkg, wcsv_req_if.
module wcsv_front import wcsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   wcsv_req_if.sink   req,
   output logic       push,
   output token_type  push_token,
   input  logic       queue_full
);

   typedef enum logic [2:0] {
      F_COLLECT = 3'b001,
      F_ARGMAX  = 3'b010,
      F_PUSH    = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   frame_type         pend_ff, pend_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CLS_W-1:0]  cnt_ff, cnt_in;
   score_type         best_ff, best_in;
   logic [CLS_W-1:0]  best_cls_ff, best_cls_in;

   logic      accept;
   logic      is_clear;
   logic      is_elem;
   logic      last_step;
   score_type cur_score;

   // Input beats are taken only while collecting and with room in the queue.
   assign req.ready = (state_ff == F_COLLECT) && !queue_full;
   assign accept    = req.valid && req.ready;
   assign is_clear  = accept && req.mode;
   assign is_elem   = accept && !req.mode;

   // Argmax walk: one class per cycle.
   assign cur_score = pend_ff[cnt_ff];
   assign last_step = (POS_W'(cnt_ff) + POS_W'(1)) == cfg.classes;

   // A clear goes straight into the queue; a frame goes after its walk.
   assign push = is_clear || ((state_ff == F_PUSH) && !queue_full);
   always_comb begin
      push_token.kind   = is_clear ? TOKEN_CLEAR : TOKEN_FRAME;
      push_token.scores = pend_ff;
      push_token.winner = best_cls_ff;
   end

   // Next-state logic.
   always_comb begin
      state_in    = state_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      best_in     = best_ff;
      best_cls_in = best_cls_ff;
      unique case (state_ff)
         F_COLLECT: begin
            if (is_clear) begin
               pend_in = '0;
               pos_in  = '0;
            end else if (is_elem) begin
               // Scores beyond the class count are dropped.
               if (pos_ff < cfg.classes) begin
                  pend_in[pos_ff[CLS_W-1:0]] = req.score;
               end
               if (pos_ff < POS_W'(MAX_CLASSES)) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (req.frame_end) begin
                  state_in = F_ARGMAX;
                  cnt_in   = '0;
               end
            end
         end
         F_ARGMAX: begin
            // The first maximum wins.
            if (cnt_ff == '0 || cur_score > best_ff) begin
               best_in     = cur_score;
               best_cls_in = cnt_ff;
            end
            cnt_in = cnt_ff + CLS_W'(1);
            if (last_step) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_COLLECT;
               pend_in  = '0;
               pos_in   = '0;
            end
         end
         default: begin
            state_in = F_COLLECT;
         end
      endcase
   end

   // Control state and the pending frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_COLLECT;
         pend_ff  <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Running argmax.
   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_cls_ff <= best_cls_in;
   end

endmodule

/* design/wcsv_queue.sv */
// wcsv_queue: short FIFO of frame and clear tokens between front and back.
// Depends on wcsv_pkg.
module wcsv_queue import wcsv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output token_type head,
   output logic      empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

/* design/wcsv_back.sv */
// wcsv_back: window bookkeeping. Evicts old frames, inserts new ones, keeps
// per-class sums and votes and drives the result register.
// Depends on wcsv_pkg, wcsv_rsp_if and wcsv_ram.
module wcsv_back import wcsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  token_type   head,
   input  logic        empty,
   output logic        pop,
   wcsv_rsp_if.source  rsp
);

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_EVICT  = 4'b0010,
      B_INSERT = 4'b0100,
      B_RESULT = 4'b1000
   } back_state_type;

   localparam int STEP_W = $clog2(MAX_CLASSES + 2);
   localparam int X5_W   = FILL_W + 3;

   back_state_type     state_ff, state_in;
   sum_type            sum_ff [MAX_CLASSES];
   sum_type            sum_in [MAX_CLASSES];
   logic [FILL_W-1:0]  vote_ff [MAX_CLASSES];
   logic [FILL_W-1:0]  vote_in [MAX_CLASSES];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CLS_W-1:0]   evict_win_ff, evict_win_in;
   sum_type            best_sum_ff, best_sum_in;
   logic [CLS_W-1:0]   best_cls_ff, best_cls_in;
   logic [FILL_W-1:0]  top_ff, top_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLS_W-1:0]   rsp_cls_ff, rsp_cls_in;
   logic               rsp_unknown_ff, rsp_unknown_in;
   logic [FILL_W-1:0]  rsp_top_ff, rsp_top_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic [CLS_W-1:0]        walk_cls;
   logic [SLOT_W:0]         slot_sum;
   logic [SLOT_W-1:0]       ins_slot;
   logic [SCORE_WIDTH-1:0]  score_rdata;
   logic [SCORE_WIDTH-1:0]  walk_score;
   logic [CLS_W-1:0]        win_rdata;
   logic                    score_we;
   logic                    win_we;
   logic [ADDR_W-1:0]       score_raddr;
   logic [ADDR_W-1:0]       score_waddr;
   sum_type                 ext_score;
   sum_type                 walk_sum;
   sum_type                 new_sum;
   logic [FILL_W-1:0]       walk_vote;
   logic [FILL_W-1:0]       new_vote;
   logic [X5_W-1:0]         top_x5;
   logic                    load_rsp;

   // Class visited this cycle: in eviction it is the step count less two, as the registered score read runs ahead.
   assign walk_cls = (state_ff == B_EVICT) ? CLS_W'(step_ff - STEP_W'(2))
                                           : step_ff[CLS_W-1:0];
   assign walk_sum  = sum_ff[walk_cls];
   assign walk_vote = vote_ff[walk_cls];

   // Slot of the incoming frame: oldest plus fill, modulo the depth.
   assign slot_sum = (SLOT_W + 1)'(oldest_ff) + (SLOT_W + 1)'(fill_ff);
   assign ins_slot = (slot_sum >= (SLOT_W + 1)'(WINDOW_DEPTH))
                   ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW_DEPTH))
                   : SLOT_W'(slot_sum);

   // Score operand of the walk, sign extended to sum width.
   assign walk_score = (state_ff == B_EVICT) ? score_rdata : head.scores[walk_cls];
   assign ext_score  = {{(SUM_W - SCORE_WIDTH){walk_score[SCORE_WIDTH-1]}}, walk_score};
   assign new_sum    = walk_sum + ext_score;
   assign new_vote   = walk_vote + ((walk_cls == head.winner) ? FILL_W'(1) : FILL_W'(0));

   // Score store: one row of MAX_CLASSES entries per window slot.
   assign score_we    = (state_ff == B_INSERT);
   assign score_waddr = {ins_slot, step_ff[CLS_W-1:0]};
   assign score_raddr = {oldest_ff, CLS_W'(step_ff - STEP_W'(1))};

   wcsv_ram #(
      .WIDTH (SCORE_WIDTH),
      .DEPTH (WINDOW_DEPTH * MAX_CLASSES)
   ) u_score_ram (
      .clock (clock),
      .we    (score_we),
      .waddr (score_waddr),
      .wdata (head.scores[walk_cls]),
      .raddr (score_raddr),
      .rdata (score_rdata)
   );

   // Frame winner store: one class index per window slot.
   assign win_we = (state_ff == B_INSERT) && (step_ff == '0);

   wcsv_ram #(
      .WIDTH (CLS_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_winner_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (ins_slot),
      .wdata (head.winner),
      .raddr (oldest_ff),
      .rdata (win_rdata)
   );

   // Result register is loaded when empty or being taken.
   assign load_rsp = (state_ff == B_RESULT) && (!rsp_valid_ff || rsp.ready);
   assign pop = load_rsp ||
                ((state_ff == B_IDLE) && !empty && (head.kind == TOKEN_CLEAR));
   assign top_x5 = (X5_W'(top_ff) << 2) + X5_W'(top_ff);

   // Window sequencer.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      vote_in      = vote_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      step_in      = step_ff;
      evict_win_in = evict_win_ff;
      best_sum_in  = best_sum_ff;
      best_cls_in  = best_cls_ff;
      top_in       = top_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               if (head.kind == TOKEN_CLEAR) begin
                  sum_in    = '{default: '0};
                  vote_in   = '{default: '0};
                  fill_in   = '0;
                  oldest_in = '0;
               end else if (fill_ff >= cfg.length) begin
                  state_in = B_EVICT;
                  step_in  = '0;
               end else begin
                  state_in = B_INSERT;
                  step_in  = '0;
               end
            end
         end
         B_EVICT: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               evict_win_in = win_rdata;
            end
            // Take the oldest frame's scores and vote back out.
            if (step_ff >= STEP_W'(2)) begin
               sum_in[walk_cls] = walk_sum - ext_score;
               if (walk_cls == evict_win_ff && walk_vote != '0) begin
                  vote_in[walk_cls] = walk_vote - FILL_W'(1);
               end
            end
            if (step_ff == STEP_W'(MAX_CLASSES + 1)) begin
               fill_in   = fill_ff - FILL_W'(1);
               oldest_in = (oldest_ff == SLOT_W'(WINDOW_DEPTH - 1))
                         ? '0 : oldest_ff + SLOT_W'(1);
               step_in   = '0;
               if (fill_ff <= cfg.length) begin
                  state_in = B_INSERT;
               end
            end
         end
         B_INSERT: begin
            step_in          = step_ff + STEP_W'(1);
            sum_in[walk_cls] = new_sum;
            vote_in[walk_cls] = new_vote;
            // Decision over the updated sums and votes, lowest index on ties.
            if (step_ff == '0) begin
               best_sum_in = new_sum;
               best_cls_in = '0;
               top_in      = new_vote;
            end else if (POS_W'(walk_cls) < cfg.classes) begin
               if (new_sum > best_sum_ff) begin
                  best_sum_in = new_sum;
                  best_cls_in = walk_cls;
               end
               if (new_vote > top_ff) begin
                  top_in = new_vote;
               end
            end
            if (step_ff == STEP_W'(MAX_CLASSES - 1)) begin
               fill_in  = fill_ff + FILL_W'(1);
               state_in = B_RESULT;
            end
         end
         B_RESULT: begin
            if (load_rsp) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_cls_in     = rsp_cls_ff;
      rsp_unknown_in = rsp_unknown_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_fill_in    = rsp_fill_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_cls_in     = best_cls_ff;
         rsp_unknown_in = top_x5 < X5_W'(fill_ff);
         rsp_top_in     = top_ff;
         rsp_fill_in    = fill_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.decided_class = rsp_cls_ff;
   assign rsp.unknown       = rsp_unknown_ff;
   assign rsp.top_votes     = rsp_top_ff;
   assign rsp.frames_held   = rsp_fill_ff;

   // Control state, sums and votes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= '{default: '0};
         vote_ff      <= '{default: '0};
         fill_ff      <= '0;
         oldest_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         vote_ff      <= vote_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk results and result payload.
   always_ff @(posedge clock) begin
      evict_win_ff   <= evict_win_in;
      best_sum_ff    <= best_sum_in;
      best_cls_ff    <= best_cls_in;
      top_ff         <= top_in;
      rsp_cls_ff     <= rsp_cls_in;
      rsp_unknown_ff <= rsp_unknown_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

endmodule

/* design/windowed_class_score_vote.sv */
// windowed_class_score_vote: top level with configuration registers.
// Depends on wcsv_pkg, wcsv_req_if, wcsv_rsp_if, wcsv_front, wcsv_queue, wcsv_back.
//
// Usage:
//   req_bus carries one class score per beat (mode 0) with frame_end on the
//   last score of a frame, or a clear (mode 1). rsp_bus returns one decision
//   beat per frame end: decided class, top vote count, frames held, unknown.
//   csr_we/csr_index/csr_wdata write window_length (index 0) and class_count
//   (index 1); write them only while no frame is in flight.
// Sequence:
//   Scores are taken one per cycle while the front is collecting and the queue
//   has room. A frame end starts the argmax walk over class_count classes, then
//   the frame enters the queue; the input is held off meanwhile. The back end
//   walks the score store over every class to evict each old frame, then walks
//   every class again to insert the frame and decide.
// Reset and stall:
//   Reset empties the window and sets window_length 50, class_count 16. There
//   is no clearing pass. A stalled result waits in its register while the
//   front keeps collecting; two frames can queue before the input stalls.
module windowed_class_score_vote import wcsv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wcsv_req_if.sink              req_bus,
   wcsv_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [CCNT_W-1:0] ccnt_ff, ccnt_in;
   cfg_type           cfg;
   logic              push;
   token_type         push_token;
   logic              queue_full;
   logic              pop;
   token_type         head;
   logic              empty;

   // Configuration register writes.
   always_comb begin
      wlen_in = wlen_ff;
      ccnt_in = ccnt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: wlen_in = csr_wdata[WLEN_W-1:0];
            CSR_CLASS_COUNT:   ccnt_in = csr_wdata[CCNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_RESET;
         ccnt_ff <= CCNT_RESET;
      end else begin
         wlen_ff <= wlen_in;
         ccnt_ff <= ccnt_in;
      end
   end

   // Register values limited to their legal ranges.
   always_comb begin
      cfg.length  = eff_length(wlen_ff);
      cfg.classes = eff_classes(ccnt_ff);
   end

   wcsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_bus),
      .push       (push),
      .push_token (push_token),
      .queue_full (queue_full)
   );

   wcsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   wcsv_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

/* design/wcsv_checker.sv */
// wcsv_checker: port-level assertions on the result channel, bound to the
// top level. Depends on wcsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcsv_checker import wcsv_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CLS_W-1:0]  decided_class,
   input logic              unknown,
   input logic [FILL_W-1:0] top_votes,
   input logic [FILL_W-1:0] frames_held
);

   logic [FILL_W+2:0] votes_x5;

   assign votes_x5 = ((FILL_W + 3)'(top_votes) << 2) + (FILL_W + 3)'(top_votes);

   // A stalled decision must not change.
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(decided_class) && $stable(unknown) && $stable(top_votes) && $stable(frames_held), "Decision changed while stalled")

   // The window always holds the new frame and never more than its depth.
   `ASSERT_CLKD(a_fill_range, clock, reset, rsp_valid |-> frames_held != '0 && frames_held <= FILL_W'(WINDOW_DEPTH), "Frames held out of range")

   // The newest frame voted, and no class has more votes than frames held.
   `ASSERT_CLKD(a_vote_range, clock, reset, rsp_valid |-> top_votes != '0 && top_votes <= frames_held, "Top votes out of range")

   // Unknown flag agrees with the vote count and the fill.
   `ASSERT_CLKD(a_unknown_flag, clock, reset, rsp_valid |-> unknown == (votes_x5 < (FILL_W + 3)'(frames_held)), "Unknown flag inconsistent")

   // Reset leaves no decision pending.
   `ASSERT_CLKD_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "Decision valid after reset")

endmodule

bind windowed_class_score_vote wcsv_checker u_wcsv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .decided_class (rsp_bus.decided_class),
   .unknown       (rsp_bus.unknown),
   .top_votes     (rsp_bus.top_votes),
   .frames_held   (rsp_bus.frames_held)
);

/* bench/testbench.sv */
// testbench: self-checking bench for windowed_class_score_vote, with a score
// predictor in a scoreboard class, random idling on both channels and CSR phases.
// Depends on wcsv_pkg, wcsv_req_if, wcsv_rsp_if and the windowed_class_score_vote RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wcsv_pkg::*;

   localparam score_type SCORE_MIN     = 16'sh8000;
   localparam score_type SCORE_MAX     = 16'sh7fff;
   localparam int        SETTLE_CYCLES = 100;
   localparam int        LONG_HOLD     = 400;

   // One decision beat as the result channel carries it.
   typedef struct packed {
      logic [CLS_W-1:0]  decided_class;
      logic              unknown;
      logic [FILL_W-1:0] top_votes;
      logic [FILL_W-1:0] frames_held;
   } decision_type;

   // Predicts decisions from accepted score beats and checks the decision beats.
   class decision_scoreboard;
      int unsigned  length_reg;
      int unsigned  classes_reg;
      score_type    held_scores [WINDOW_DEPTH][MAX_CLASSES];
      int           held_winner [WINDOW_DEPTH];
      int           class_sums  [MAX_CLASSES];
      int           vote_tally  [MAX_CLASSES];
      score_type    frame_scores[MAX_CLASSES];
      int           fill;
      int           oldest;
      int           position;
      int           errors;
      decision_type expected_decisions[$];

      function new();
         length_reg  = WLEN_RESET;
         classes_reg = CCNT_RESET;
         errors      = 0;
         wipe_window();
      endfunction

      // Empties the window, all sums and votes and the frame being collected.
      function void wipe_window();
         for (int c = 0; c < MAX_CLASSES; c++) begin
            class_sums[c]   = 0;
            vote_tally[c]   = 0;
            frame_scores[c] = '0;
         end
         fill     = 0;
         oldest   = 0;
         position = 0;
      endfunction

      function int window_limit();
         if (length_reg == 0) begin
            return 1;
         end
         if (length_reg > WINDOW_DEPTH) begin
            return WINDOW_DEPTH;
         end
         return int'(length_reg);
      endfunction

      function int class_limit();
         if (classes_reg == 0) begin
            return 1;
         end
         if (classes_reg > MAX_CLASSES) begin
            return MAX_CLASSES;
         end
         return int'(classes_reg);
      endfunction

      function void set_registers(int unsigned wl, int unsigned cc);
         length_reg  = wl & 'h7f;
         classes_reg = cc & 'h1f;
      endfunction

      function int outstanding();
         return expected_decisions.size();
      endfunction

      // Notes one accepted score beat; a frame end queues the expected decision.
      function void note_beat(token_kind_type kind, score_type value, logic last);
         int           ncls;
         int           len;
         int           best;
         int           top;
         int           slot;
         int           best_sum;
         score_type    best_score;
         decision_type d;
         if (kind == TOKEN_CLEAR) begin
            wipe_window();
            return;
         end
         ncls = class_limit();
         len  = window_limit();
         // Scores past the class count are dropped; the position saturates.
         if (position < ncls) begin
            frame_scores[position] = value;
         end
         if (position < MAX_CLASSES) begin
            position++;
         end
         if (!last) begin
            return;
         end

         // Frame argmax over the active classes; the first maximum wins.
         best       = 0;
         best_score = frame_scores[0];
         for (int c = 1; c < ncls; c++) begin
            if (frame_scores[c] > best_score) begin
               best_score = frame_scores[c];
               best       = c;
            end
         end

         // Evict the oldest frames until the new one fits.
         while (fill >= len) begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
               class_sums[c] -= held_scores[oldest][c];
            end
            if (vote_tally[held_winner[oldest]] > 0) begin
               vote_tally[held_winner[oldest]]--;
            end
            oldest = (oldest + 1) % WINDOW_DEPTH;
            fill--;
         end

         // Store the frame and add it to the sums and votes.
         slot = (oldest + fill) % WINDOW_DEPTH;
         for (int c = 0; c < MAX_CLASSES; c++) begin
            held_scores[slot][c] = frame_scores[c];
            class_sums[c]       += frame_scores[c];
            frame_scores[c]      = '0;
         end
         held_winner[slot] = best;
         vote_tally[best]++;
         fill++;
         position = 0;

         // Decide on the largest windowed sum, lowest index on ties.
         best     = 0;
         best_sum = class_sums[0];
         top      = vote_tally[0];
         for (int c = 1; c < ncls; c++) begin
            if (class_sums[c] > best_sum) begin
               best_sum = class_sums[c];
               best     = c;
            end
            if (vote_tally[c] > top) begin
               top = vote_tally[c];
            end
         end
         d.decided_class = CLS_W'(best);
         d.unknown       = (top * 5 < fill);
         d.top_votes     = FILL_W'(top);
         d.frames_held   = FILL_W'(fill);
         expected_decisions.insert(expected_decisions.size(), d);
      endfunction

      // Compares one decision beat with the oldest expected decision.
      function void check_decision(decision_type got);
         decision_type want;
         if (expected_decisions.size() == 0) begin
            errors++;
            $display("%0t: unexpected decision: class %0d unknown %0d votes %0d held %0d",
                     $time, got.decided_class, got.unknown, got.top_votes,
                     got.frames_held);
            return;
         end
         want = expected_decisions[0];
         expected_decisions.delete(0);
         if (got !== want) begin
            errors++;
            $display("%0t: decision mismatch: expected class %0d unknown %0d votes %0d held %0d",
                     $time, want.decided_class, want.unknown, want.top_votes,
                     want.frames_held);
            $display("%0t:                    actual class %0d unknown %0d votes %0d held %0d",
                     $time, got.decided_class, got.unknown, got.top_votes, got.frames_held);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   decision_scoreboard board;
   int                 req_calm = 0;
   int                 rsp_calm = 0;
   bit                 hold_off_request = 1'b0;

   wcsv_req_if req_bus ();
   wcsv_rsp_if rsp_bus ();

   windowed_class_score_vote uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Idle length for either side: mostly none or short, a few long, and
   // now and then a calm stretch with no idling at all.
   function automatic int draw_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Scores lean toward the extremes and a narrow band near zero for ties.
   function automatic score_type draw_score();
      case ($urandom_range(0, 9))
         0: begin
            return SCORE_MIN;
         end
         1: begin
            return SCORE_MAX;
         end
         2, 3: begin
            return score_type'(int'($urandom_range(0, 4)) - 2);
         end
         default: begin
            return score_type'($urandom());
         end
      endcase
   endfunction

   // Offers one score beat after a random gap and waits until it is taken.
   task automatic put_beat(input token_kind_type kind, input score_type value,
                           input logic last);
      int gap;
      gap = draw_idle(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= kind;
      req_bus.score     <= value;
      req_bus.frame_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_beat(kind, value, last);
   endtask

   task automatic send_frame(input int length);
      for (int i = 0; i < length; i++) begin
         put_beat(TOKEN_FRAME, draw_score(), i == length - 1);
      end
   endtask

   // Stops offering, waits for every expected decision and lets the block settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers once the block has gone idle.
   task automatic reconfigure(input int unsigned wl, input int unsigned cc);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= CSR_DATA_W'(wl);
      @(posedge clock);
      csr_index <= CSR_CLASS_COUNT;
      csr_wdata <= CSR_DATA_W'(cc);
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_registers(wl, cc);
   endtask

   // Mostly whole frames with random scores, plus short and overlong frames
   // and the odd clear. A phase always ends on a frame end or a clear.
   task automatic run_phase(input int count);
      int sent;
      int ncls;
      int r;
      sent = 0;
      ncls = board.class_limit();
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            put_beat(TOKEN_CLEAR, score_type'($urandom()), 1'($urandom_range(0, 1)));
            sent++;
         end else if (r < 86) begin
            send_frame(ncls);
            sent += ncls;
         end else if (r < 93) begin
            send_frame($urandom_range(1, ncls));
            sent += ncls;
         end else begin
            send_frame(ncls + $urandom_range(1, 6));
            sent += ncls;
         end
      end
   endtask

   // Result side: checks each decision beat and drives ready with random stalls.
   initial begin
      decision_type got;
      int           stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.decided_class = rsp_bus.decided_class;
            got.unknown       = rsp_bus.unknown;
            got.top_votes     = rsp_bus.top_votes;
            got.frames_held   = rsp_bus.frames_held;
            board.check_decision(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = LONG_HOLD;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = draw_idle(rsp_calm);
         end
      end
   end

   // Stimulus: directed frames first, then random phases over register settings.
   initial begin
      int unsigned phase_wl      [8];
      int unsigned phase_classes [8];
      int          phase_items   [8];
      phase_wl          = '{127, 2, 64, 5, 0, 65, 20, 3};
      phase_classes     = '{0, 3, 16, 4, 31, 17, 1, 2};
      phase_items       = '{80, 40, 100, 60, 40, 60, 40, 40};
      board             = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.mode      = TOKEN_FRAME;
      req_bus.score     = '0;
      req_bus.frame_end = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_WINDOW_LENGTH;
      csr_wdata         = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a one-score frame, a short frame of minimum scores
      // where the missing classes win as zeros, a clear with frame_end set,
      // and a tie that goes to the lowest class.
      put_beat(TOKEN_FRAME, SCORE_MAX, 1'b1);
      put_beat(TOKEN_FRAME, SCORE_MIN, 1'b0);
      put_beat(TOKEN_FRAME, SCORE_MIN, 1'b0);
      put_beat(TOKEN_FRAME, SCORE_MIN, 1'b1);
      put_beat(TOKEN_CLEAR, score_type'($urandom()), 1'b1);
      put_beat(TOKEN_FRAME, 16'sd5, 1'b0);
      put_beat(TOKEN_FRAME, 16'sd5, 1'b1);

      // One-frame window over two classes: extra scores are dropped and a
      // frame end on an extra score still closes the frame.
      reconfigure(1, 2);
      put_beat(TOKEN_FRAME, 16'sd100, 1'b0);
      put_beat(TOKEN_FRAME, 16'sd200, 1'b0);
      put_beat(TOKEN_FRAME, -16'sd300, 1'b0);
      put_beat(TOKEN_FRAME, 16'sd7, 1'b1);
      put_beat(TOKEN_FRAME, SCORE_MIN, 1'b0);
      put_beat(TOKEN_FRAME, SCORE_MAX, 1'b1);

      // Fixed phases cover the register extremes, a full window shrunk to two
      // frames and a class count change without a clear.
      for (int p = 0; p < 8; p++) begin
         reconfigure(phase_wl[p], phase_classes[p]);
         if (p == 2) begin
            hold_off_request = 1'b1;
         end
         run_phase(phase_items[p]);
      end
      repeat (2) begin
         reconfigure($urandom_range(0, 127), $urandom_range(0, 31));
         run_phase(40);
      end

      wait_idle();
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

/* windowed_class_score_vote.f */
+incdir+design
design/wcsv_pkg.sv
design/wcsv_req_if.sv
design/wcsv_rsp_if.sv
design/wcsv_ram.sv
design/wcsv_front.sv
design/wcsv_queue.sv
design/wcsv_back.sv
design/windowed_class_score_vote.sv
design/wcsv_checker.sv
bench/testbench.sv
